FILE: hdl/mte_pkg.sv
// shared types, command codes and fixed-point helpers of the training engine
`timescale 1ns / 1ps

package mte_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int MAX_NEURONS = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int FRAC_BITS   = 12;
    localparam int LAYER_BITS  = 2;
    localparam int NEURON_BITS = 4;
    localparam int NEURON_DEPTH = MAX_LAYERS * MAX_NEURONS;
    localparam int WEIGHT_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * MAX_NEURONS;
    localparam int NADDR_BITS = LAYER_BITS + NEURON_BITS;
    localparam int WADDR_BITS = LAYER_BITS + 2 * NEURON_BITS;

    localparam logic signed [VALUE_WIDTH-1:0] VAL_ONE = 16'sd4096;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    localparam logic [3:0] CMD_WR_WEIGHT = 4'd0;
    localparam logic [3:0] CMD_WR_INPUT  = 4'd1;
    localparam logic [3:0] CMD_WR_ERROR  = 4'd2;
    localparam logic [3:0] CMD_FORWARD   = 4'd3;
    localparam logic [3:0] CMD_BACKWARD  = 4'd4;
    localparam logic [3:0] CMD_CLR_GRAD  = 4'd5;
    localparam logic [3:0] CMD_ACC_GRAD  = 4'd6;
    localparam logic [3:0] CMD_APPLY     = 4'd7;
    localparam logic [3:0] CMD_RD_NEURON = 4'd8;
    localparam logic [3:0] CMD_RD_ERROR  = 4'd9;
    localparam logic [3:0] CMD_RD_WEIGHT = 4'd10;

    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_SIZE0       = 3'd1;
    localparam logic [2:0] REG_SIZE1       = 3'd2;
    localparam logic [2:0] REG_SIZE2       = 3'd3;
    localparam logic [2:0] REG_SIZE3       = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROW,
        ST_ROWW,
        ST_ELEM,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_WB,
        ST_STORE,
        ST_RDW,
        ST_FIN
    } state_t;

    function automatic value_t sat17(input logic signed [16:0] v);
        value_t r;
        if (v > 17'sd32767)
            r = 16'sh7fff;
        else if (v < -17'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic value_t sat_add(input value_t a, input value_t b);
        logic signed [16:0] s;
        s = {a[15], a} + {b[15], b};
        return sat17(s);
    endfunction

    function automatic value_t one_minus(input value_t y);
        logic signed [16:0] s;
        s = {VAL_ONE[15], VAL_ONE} - {y[15], y};
        return sat17(s);
    endfunction

    // product floored by 2^12, then saturated
    function automatic value_t qmul(input value_t a, input value_t b);
        logic signed [31:0] p;
        logic signed [19:0] q;
        value_t r;
        p = a * b;
        q = p[31:FRAC_BITS];
        if (q > 20'sd32767)
            r = 16'sh7fff;
        else if (q < -20'sd32768)
            r = 16'sh8000;
        else
            r = q[15:0];
        return r;
    endfunction

    // piecewise linear sigmoid
    function automatic value_t sigmoid(input value_t x);
        logic [16:0] a;
        logic [15:0] y;
        value_t r;
        a = x[15] ? (17'd0 - {x[15], x}) : {1'b0, x};
        if (a >= 17'd20480)
            y = 16'd4096;
        else if (a >= 17'd9728)
            y = {5'd0, a[15:5]} + 16'd3456;
        else if (a >= 17'd4096)
            y = {3'd0, a[15:3]} + 16'd2560;
        else
            y = {2'd0, a[15:2]} + 16'd2048;
        r = x[15] ? (VAL_ONE - value_t'(y)) : value_t'(y);
        return r;
    endfunction

endpackage

FILE: hdl/mlp_training_engine_unit.sv
// top level of the sigmoid network training engine
`timescale 1ns / 1ps

// one command per input beat, one result beat per command. load and read
// commands register their result beat in ST_RDW (reads) or ST_FIN. compute
// commands sweep every weight of every layer pair in use with one memory read
// and one shared multiplier: per weight ST_ELEM, then ST_MUL0 (on to ST_MUL2
// for backward, ST_MUL3 for accumulate) and ST_WB; per row ST_ROW, ST_ROWW
// and, for forward and backward, ST_STORE. no new command is taken until the
// previous result beat has gone out.

module mlp_training_engine_unit
    import mte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // layer_sel, row_index, col_index, data_value, learn_rate
    input  logic [3:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // read_value, status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    state_t state_reg, state_next;

    logic [2:0] layer_count_reg;
    logic [4:0] size_reg [MAX_LAYERS];
    logic [4:0] sz [MAX_LAYERS];
    logic [2:0] cnt;

    logic [3:0]       cmd_reg;
    value_t           rate_reg;
    logic             st_reg;
    logic [1:0]       lay_reg;
    logic [4:0]       j_reg;
    logic [4:0]       k_reg;
    value_t           acc_reg;
    value_t           src_reg;
    value_t           d_reg;
    logic [WADDR_BITS-1:0] wa_reg;

    logic   m_val_reg;
    value_t m_rv_reg;
    logic   m_st_reg;

    // memories
    value_t wmem [WEIGHT_DEPTH];
    value_t gmem [WEIGHT_DEPTH];
    value_t nmem [NEURON_DEPTH];
    value_t emem [NEURON_DEPTH];
    logic [NEURON_DEPTH-1:0] nvalid_reg;
    logic [NEURON_DEPTH-1:0] evalid_reg;
    value_t wq_reg, gq_reg, nq_reg, eq_reg;
    logic   nvq_reg, evq_reg;
    value_t wrd, grd, nrd, erd;

    logic                  w_re, w_we, g_re, g_we, n_re, n_we, e_re, e_we;
    logic [WADDR_BITS-1:0] w_ra, w_wa;
    logic [NADDR_BITS-1:0] n_ra, n_wa, e_ra, e_wa;
    value_t                w_wd, g_wd, n_wd, e_wd;

    value_t mul_a, mul_b, mq;

    // input fields
    logic [3:0] in_req;
    logic [1:0] in_lsel;
    logic [3:0] in_row, in_col;
    value_t     in_data, in_rate;
    logic       accept;
    logic       bad;
    logic [2:0] lsel_p1;
    logic [4:0] size_lsel, size_lsel_p1, size_last;
    logic [1:0] last_layer;
    logic       is_compute;
    logic [4:0] jcount, kcount;
    logic [1:0] lay_p1;
    logic       last_layer_pass;

    assign in_req  = s_tuser;
    assign in_lsel = s_tdata[1:0];
    assign in_row  = s_tdata[5:2];
    assign in_col  = s_tdata[9:6];
    assign in_data = s_tdata[25:10];
    assign in_rate = s_tdata[41:26];

    assign s_tready = (state_reg == ST_IDLE) && !m_val_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_val_reg;
    assign m_tdata  = {7'd0, m_st_reg, m_rv_reg};
    assign pready   = 1'b1;

    // configuration
    always_comb
    begin
        for (int l = 0; l < MAX_LAYERS; l++)
            sz[l] = (size_reg[l] > 5'(MAX_NEURONS)) ? 5'(MAX_NEURONS) : size_reg[l];
        cnt = (layer_count_reg > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : layer_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_count_reg <= 3'd3;
            for (int l = 0; l < MAX_LAYERS; l++)
                size_reg[l] <= 5'd16;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[4:2])
                REG_LAYER_COUNT: layer_count_reg <= pwdata[2:0];
                REG_SIZE0:       size_reg[0] <= pwdata[4:0];
                REG_SIZE1:       size_reg[1] <= pwdata[4:0];
                REG_SIZE2:       size_reg[2] <= pwdata[4:0];
                REG_SIZE3:       size_reg[3] <= pwdata[4:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_LAYER_COUNT: prdata = {29'd0, layer_count_reg};
            REG_SIZE0:       prdata = {27'd0, size_reg[0]};
            REG_SIZE1:       prdata = {27'd0, size_reg[1]};
            REG_SIZE2:       prdata = {27'd0, size_reg[2]};
            REG_SIZE3:       prdata = {27'd0, size_reg[3]};
            default:         prdata = 32'd0;
        endcase
    end

    // index checks of load and read commands
    always_comb
    begin
        lsel_p1      = {1'b0, in_lsel} + 3'd1;
        size_lsel    = sz[in_lsel];
        size_lsel_p1 = (lsel_p1 < 3'(MAX_LAYERS)) ? sz[lsel_p1[1:0]] : 5'd0;
        last_layer   = 2'(cnt - 3'd1);
        size_last    = sz[last_layer];
        case (in_req)
            CMD_WR_WEIGHT, CMD_RD_WEIGHT:
                bad = (lsel_p1 >= cnt) || ({1'b0, in_row} >= size_lsel)
                      || ({1'b0, in_col} >= size_lsel_p1);
            CMD_WR_INPUT:
                bad = (cnt < 3'd1) || ({1'b0, in_row} >= sz[0]);
            CMD_WR_ERROR:
                bad = (cnt < 3'd1) || ({1'b0, in_row} >= size_last);
            CMD_RD_NEURON, CMD_RD_ERROR:
                bad = ({1'b0, in_lsel} >= cnt) || ({1'b0, in_row} >= size_lsel);
            default:
                bad = 1'b0;
        endcase
        is_compute = (in_req == CMD_FORWARD) || (in_req == CMD_BACKWARD)
                     || (in_req == CMD_CLR_GRAD) || (in_req == CMD_ACC_GRAD)
                     || (in_req == CMD_APPLY);
    end

    // loop bounds, lay_reg is always the lower layer of the pair
    always_comb
    begin
        lay_p1 = lay_reg + 2'd1;
        if (cmd_reg == CMD_FORWARD)
        begin
            jcount = sz[lay_p1];
            kcount = sz[lay_reg];
        end
        else
        begin
            jcount = sz[lay_reg];
            kcount = sz[lay_p1];
        end
        if (cmd_reg == CMD_BACKWARD)
            last_layer_pass = (lay_reg == 2'd0);
        else
            last_layer_pass = ({1'b0, lay_reg} + 3'd2 >= cnt);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_compute)
                        state_next = (cnt < 3'd2) ? ST_FIN : ST_ROW;
                    else if (!bad && ((in_req == CMD_RD_NEURON) || (in_req == CMD_RD_ERROR)
                             || (in_req == CMD_RD_WEIGHT)))
                        state_next = ST_RDW;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_ROW:
            begin
                if (j_reg < jcount)
                    state_next = ST_ROWW;
                else if (last_layer_pass)
                    state_next = ST_FIN;
            end
            ST_ROWW:
                state_next = ST_ELEM;
            ST_ELEM:
            begin
                if (k_reg < kcount)
                    state_next = ST_MUL0;
                else if ((cmd_reg == CMD_FORWARD) || (cmd_reg == CMD_BACKWARD))
                    state_next = ST_STORE;
                else
                    state_next = ST_ROW;
            end
            ST_MUL0:
            begin
                if ((cmd_reg == CMD_BACKWARD) || (cmd_reg == CMD_ACC_GRAD))
                    state_next = ST_MUL1;
                else
                    state_next = ST_WB;
            end
            ST_MUL1:
                state_next = ST_MUL2;
            ST_MUL2:
                state_next = (cmd_reg == CMD_ACC_GRAD) ? ST_MUL3 : ST_WB;
            ST_MUL3:
                state_next = ST_WB;
            ST_WB:
                state_next = ST_ELEM;
            ST_STORE:
                state_next = ST_ROW;
            ST_RDW:
                state_next = ST_IDLE;
            ST_FIN:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // memory ports and multiplier operands
    always_comb
    begin
        w_re = 1'b0; w_we = 1'b0; g_re = 1'b0; g_we = 1'b0;
        n_re = 1'b0; n_we = 1'b0; e_re = 1'b0; e_we = 1'b0;
        w_ra = {in_lsel, in_row, in_col};
        w_wa = wa_reg;
        n_ra = {in_lsel, in_row};
        e_ra = {in_lsel, in_row};
        n_wa = {lay_p1, j_reg[3:0]};
        e_wa = {lay_reg, j_reg[3:0]};
        w_wd = sat_add(wrd, grd);
        g_wd = (cmd_reg == CMD_CLR_GRAD) ? value_t'(0) : sat_add(grd, mq);
        n_wd = sigmoid(acc_reg);
        e_wd = acc_reg;
        mul_a = nrd;
        mul_b = wrd;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !bad)
                begin
                    case (in_req)
                        CMD_WR_WEIGHT:
                        begin
                            w_we = 1'b1;
                            w_wa = {in_lsel, in_row, in_col};
                            w_wd = in_data;
                        end
                        CMD_WR_INPUT:
                        begin
                            n_we = 1'b1;
                            n_wa = {2'd0, in_row};
                            n_wd = in_data;
                        end
                        CMD_WR_ERROR:
                        begin
                            e_we = 1'b1;
                            e_wa = {last_layer, in_row};
                            e_wd = in_data;
                        end
                        CMD_RD_NEURON: n_re = 1'b1;
                        CMD_RD_ERROR:  e_re = 1'b1;
                        CMD_RD_WEIGHT: w_re = 1'b1;
                        default:       ;
                    endcase
                end
            end
            ST_ROW:
            begin
                n_re = 1'b1;
                n_ra = {lay_reg, j_reg[3:0]};
            end
            ST_ELEM:
            begin
                if (k_reg < kcount)
                begin
                    w_re = 1'b1;
                    g_re = 1'b1;
                    n_re = 1'b1;
                    e_re = 1'b1;
                    if (cmd_reg == CMD_FORWARD)
                    begin
                        w_ra = {lay_reg, k_reg[3:0], j_reg[3:0]};
                        n_ra = {lay_reg, k_reg[3:0]};
                    end
                    else
                    begin
                        w_ra = {lay_reg, j_reg[3:0], k_reg[3:0]};
                        n_ra = {lay_p1, k_reg[3:0]};
                    end
                    e_ra = {lay_p1, k_reg[3:0]};
                end
            end
            ST_MUL0:
            begin
                mul_a = nrd;
                mul_b = (cmd_reg == CMD_FORWARD) ? wrd : one_minus(nrd);
            end
            ST_MUL1:
            begin
                mul_a = erd;
                mul_b = (cmd_reg == CMD_ACC_GRAD) ? rate_reg : mq;
            end
            ST_MUL2:
            begin
                mul_a = mq;
                mul_b = (cmd_reg == CMD_ACC_GRAD) ? d_reg : wrd;
            end
            ST_MUL3:
            begin
                mul_a = mq;
                mul_b = src_reg;
            end
            ST_WB:
            begin
                if (cmd_reg == CMD_APPLY)
                    w_we = 1'b1;
                if ((cmd_reg == CMD_CLR_GRAD) || (cmd_reg == CMD_ACC_GRAD))
                    g_we = 1'b1;
            end
            ST_STORE:
            begin
                if (cmd_reg == CMD_FORWARD)
                    n_we = 1'b1;
                else
                    e_we = 1'b1;
            end
            default: ;
        endcase
    end

    mte_qmul u_qmul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .q   (mq)
    );

    // weight and gradient memories
    always_ff @(posedge clk)
    begin
        if (w_we)
            wmem[w_wa] <= w_wd;
        if (w_re)
            wq_reg <= wmem[w_ra];
        if (g_we)
            gmem[w_wa] <= g_wd;
        if (g_re)
            gq_reg <= gmem[w_ra];
    end

    // neuron and error memories, entries read as zero until written
    always_ff @(posedge clk)
    begin
        if (n_we)
            nmem[n_wa] <= n_wd;
        if (n_re)
            nq_reg <= nmem[n_ra];
        if (e_we)
            emem[e_wa] <= e_wd;
        if (e_re)
            eq_reg <= emem[e_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nvalid_reg <= '0;
            evalid_reg <= '0;
            nvq_reg    <= 1'b0;
            evq_reg    <= 1'b0;
        end
        else
        begin
            if (n_we)
                nvalid_reg[n_wa] <= 1'b1;
            if (e_we)
                evalid_reg[e_wa] <= 1'b1;
            if (n_re)
                nvq_reg <= nvalid_reg[n_ra];
            if (e_re)
                evq_reg <= evalid_reg[e_ra];
        end
    end

    assign wrd = wq_reg;
    assign grd = gq_reg;
    assign nrd = nvq_reg ? nq_reg : value_t'(0);
    assign erd = evq_reg ? eq_reg : value_t'(0);

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= CMD_WR_WEIGHT;
            st_reg    <= 1'b0;
            lay_reg   <= 2'd0;
            j_reg     <= 5'd0;
            k_reg     <= 5'd0;
            m_val_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_val_reg && m_tready)
                m_val_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= in_req;
                        st_reg  <= bad;
                        j_reg   <= 5'd0;
                        lay_reg <= (in_req == CMD_BACKWARD) ? 2'(cnt - 3'd2) : 2'd0;
                    end
                end
                ST_ROW:
                begin
                    k_reg <= 5'd0;
                    if ((j_reg >= jcount) && !last_layer_pass)
                    begin
                        j_reg   <= 5'd0;
                        lay_reg <= (cmd_reg == CMD_BACKWARD) ? lay_reg - 2'd1 : lay_p1;
                    end
                end
                ST_ELEM:
                begin
                    if ((k_reg >= kcount) && (cmd_reg != CMD_FORWARD)
                        && (cmd_reg != CMD_BACKWARD))
                        j_reg <= j_reg + 5'd1;
                end
                ST_WB:
                    k_reg <= k_reg + 5'd1;
                ST_STORE:
                    j_reg <= j_reg + 5'd1;
                ST_RDW, ST_FIN:
                    m_val_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
            rate_reg <= in_rate;
        if (state_reg == ST_ROW)
            acc_reg <= value_t'(0);
        if (state_reg == ST_ROWW)
            src_reg <= nrd;
        if (state_reg == ST_ELEM)
            wa_reg <= w_ra;
        if (state_reg == ST_MUL1)
            d_reg <= mq;
        if ((state_reg == ST_WB) && ((cmd_reg == CMD_FORWARD) || (cmd_reg == CMD_BACKWARD)))
            acc_reg <= sat_add(acc_reg, mq);
        if (state_reg == ST_RDW)
        begin
            m_st_reg <= 1'b0;
            case (cmd_reg)
                CMD_RD_NEURON: m_rv_reg <= nrd;
                CMD_RD_ERROR:  m_rv_reg <= erd;
                default:       m_rv_reg <= wrd;
            endcase
        end
        if (state_reg == ST_FIN)
        begin
            m_st_reg <= st_reg;
            m_rv_reg <= value_t'(0);
        end
    end

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("command taken while sequencer busy");

    a_bad_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[16]) |-> (m_tdata[15:0] == 16'd0))
        else $error("index error with nonzero read value");

    a_compute_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_compute) |=> !m_tvalid)
        else $error("compute command finished in one cycle");

    a_rmw_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> (!w_re && !g_re))
        else $error("read issued during write-back");

endmodule

FILE: hdl/mte_qmul.sv
// registered fixed-point multiplier shared by the forward, backward and accumulate commands
`timescale 1ns / 1ps

module mte_qmul
    import mte_pkg::*;
(
    input  logic   clk,
    input  value_t a,
    input  value_t b,
    output value_t q
);

    value_t q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= qmul(a, b);
    end

    assign q = q_reg;

endmodule
